// File: rtl/sbm_pkg.sv
// ============================================================================
// sbm_pkg: shared types and constants of the spectrum bar meter
// Field widths, register map, reset values and the state types of the
// sequencers used by the magnitude unit and the top level.
// ============================================================================
package sbm_pkg;

    // Field and register widths.
    localparam int BIN_WIDTH    = 28;
    localparam int BAR_HEIGHT_W = 13;
    localparam int BPB_W        = 8;
    localparam int FRAME_W      = 16;
    localparam int INDEX_W      = 6;
    localparam int SUM_W        = 28;
    localparam int SCALE_SHIFT  = 20;
    localparam int NUM_BARS_DEF = 64;

    // Configuration port.
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_BAR_HEIGHT   = 2'd0;
    localparam logic [1:0] REG_BINS_PER_BAR = 2'd1;
    localparam logic [1:0] REG_FRAME_BINS   = 2'd2;

    // Register reset values.
    localparam logic [BAR_HEIGHT_W-1:0] BAR_HEIGHT_RST   = 13'd256;
    localparam logic [BPB_W-1:0]        BINS_PER_BAR_RST = 8'd8;
    localparam logic [FRAME_W-1:0]      FRAME_BINS_RST   = 16'd512;

    // One input item: a complex FFT bin.
    typedef struct packed {
        logic signed [BIN_WIDTH-1:0] bin_real;
        logic signed [BIN_WIDTH-1:0] bin_imag;
    } sbm_in_t;

    // One result item: a bar height.
    typedef struct packed {
        logic [INDEX_W-1:0]      bar_index;
        logic [BAR_HEIGHT_W-1:0] bar_level;
        logic                    last_bar;
    } sbm_out_t;

    // Response of the magnitude unit.
    typedef struct packed {
        logic                 done;
        logic [BIN_WIDTH-1:0] mag;
    } sbm_mag_rsp_t;

    // Response of the serial divider.
    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } sbm_div_rsp_t;

    // Magnitude unit sequencer.
    typedef enum logic [1:0] {
        MAG_IDLE,
        MAG_SQUARE,
        MAG_ROOT
    } sbm_mag_state_t;

    // Top level sequencer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_SCALE,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } sbm_state_t;

endpackage

// File: rtl/spectrum_bar_meter_core.sv
// ============================================================================
// spectrum_bar_meter_core: FFT bins to bar heights
// Turns complex FFT bins into NUM_BARS averaged, scaled and clamped bar levels.
// ============================================================================
// Usage:
// Bins enter on the s_ channel (valid/ready), one complex bin per item. Each
// bin's magnitude is scaled by bar_height/2^20 and summed; after bins_per_bar
// bins the mean is clamped to bar_height and one bar item leaves on the m_
// channel. After the last bar the remaining bins of the frame give nothing,
// and the counters restart when frame_bins bins have been taken.
// Work per item: the magnitude unit squares, then takes the root one radicand
// bit pair per cycle, then signals done; the scaling takes one bar_height bit
// per cycle, and the sum follows. A bin that closes a bar adds the serial
// divider (28 quotient bits and a done pulse) and the output load before the
// next accept. A bin after the last bar only moves the frame position, and the
// core stays ready. One bin is worked at a time. The output register decouples
// the sides: a bin is accepted while a result waits, and a stalled result holds
// until m_ready. Reset (aresetn low, synchronous) clears the group, bar and
// frame counters, restores the register defaults and drops m_valid. The user
// must write registers over the APB port only while the block is idle; the
// block itself does not enforce this.
// ============================================================================
module spectrum_bar_meter_core
    import sbm_pkg::*;
#(
    parameter int NUM_BARS = NUM_BARS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // Bin input
    input  logic              s_valid,
    output logic              s_ready,
    input  sbm_in_t           s_payload,
    // Bar output
    output logic              m_valid,
    input  logic              m_ready,
    output sbm_out_t          m_payload
);

    localparam int BDW       = $clog2(NUM_BARS + 1);
    localparam int PW        = BIN_WIDTH + BAR_HEIGHT_W;
    localparam int CONTRIB_W = PW - SCALE_SHIFT;
    localparam int SW        = ((SUM_W > CONTRIB_W) ? SUM_W : CONTRIB_W) + 1;
    localparam int SCW       = $clog2(BAR_HEIGHT_W);
    localparam logic [SCW-1:0] SCALE_LAST = SCW'(BAR_HEIGHT_W - 1);
    localparam logic [BDW-1:0] BARS_FULL  = BDW'(NUM_BARS);
    localparam logic [BDW-1:0] BARS_LAST  = BDW'(NUM_BARS - 1);

    sbm_state_t state_reg, state_next;

    logic [BAR_HEIGHT_W-1:0] bar_height_reg, bar_height_next;
    logic [BPB_W-1:0]        bins_per_bar_reg, bins_per_bar_next;
    logic [FRAME_W-1:0]      frame_bins_reg, frame_bins_next;

    logic [SUM_W-1:0]        group_sum_reg, group_sum_next;
    logic [BPB_W-1:0]        bin_in_group_reg, bin_in_group_next;
    logic [BDW-1:0]          bars_done_reg, bars_done_next;
    logic [FRAME_W-1:0]      frame_pos_reg, frame_pos_next;

    logic [PW-1:0]           prod_reg, prod_next;
    logic [PW-1:0]           mcand_reg, mcand_next;
    logic [BAR_HEIGHT_W-1:0] hmul_reg, hmul_next;
    logic [SCW-1:0]          step_reg, step_next;
    logic [BAR_HEIGHT_W-1:0] level_reg, level_next;

    logic                    m_valid_reg, m_valid_next;
    sbm_out_t                m_payload_reg, m_payload_next;

    logic                    cfg_write;
    logic                    in_accept;
    logic                    mag_start, div_start;
    sbm_mag_rsp_t            mag_rsp;
    sbm_div_rsp_t            div_rsp;

    logic [SW-1:0]           sum_wide;
    logic [SUM_W-1:0]        sum_sat;
    logic [BPB_W-1:0]        count;
    logic [BPB_W-1:0]        bpb;
    logic                    group_close;
    logic [FRAME_W:0]        frame_pos_inc;
    logic                    frame_end;
    logic [BDW-1:0]          bars_inc;
    logic                    out_free;

    // Configuration registers
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb begin
        bar_height_next   = bar_height_reg;
        bins_per_bar_next = bins_per_bar_reg;
        frame_bins_next   = frame_bins_reg;
        if (cfg_write) begin
            case (paddr[3:2])
                REG_BAR_HEIGHT:   bar_height_next   = pwdata[BAR_HEIGHT_W-1:0];
                REG_BINS_PER_BAR: bins_per_bar_next = pwdata[BPB_W-1:0];
                REG_FRAME_BINS:   frame_bins_next   = pwdata[FRAME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BAR_HEIGHT:   prdata = DATA_W'(bar_height_reg);
            REG_BINS_PER_BAR: prdata = DATA_W'(bins_per_bar_reg);
            REG_FRAME_BINS:   prdata = DATA_W'(frame_bins_reg);
            default:          prdata = '0;
        endcase
    end

    // Arithmetic units
    sbm_magnitude u_sbm_magnitude (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mag_start),
        .re      (s_payload.bin_real),
        .im      (s_payload.bin_imag),
        .rsp     (mag_rsp)
    );

    sbm_divider u_sbm_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_sat),
        .divisor  (count),
        .rsp      (div_rsp)
    );

    // Group sum with saturation, and the group close decision.
    assign sum_wide    = SW'(group_sum_reg) + SW'(prod_reg[PW-1:SCALE_SHIFT]);
    assign sum_sat     = (sum_wide > SW'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum_wide);
    assign count       = bin_in_group_reg + 1'b1;
    assign bpb         = (bins_per_bar_reg == '0) ? BPB_W'(1) : bins_per_bar_reg;
    assign group_close = count >= bpb;

    // Frame position and bar counters.
    assign frame_pos_inc = (FRAME_W+1)'(frame_pos_reg) + (FRAME_W+1)'(1);
    assign frame_end     = frame_pos_inc >= (FRAME_W+1)'(frame_bins_reg);
    assign bars_inc      = bars_done_reg + 1'b1;

    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            bar_height_reg   <= BAR_HEIGHT_RST;
            bins_per_bar_reg <= BINS_PER_BAR_RST;
            frame_bins_reg   <= FRAME_BINS_RST;
            group_sum_reg    <= '0;
            bin_in_group_reg <= '0;
            bars_done_reg    <= '0;
            frame_pos_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            bar_height_reg   <= bar_height_next;
            bins_per_bar_reg <= bins_per_bar_next;
            frame_bins_reg   <= frame_bins_next;
            group_sum_reg    <= group_sum_next;
            bin_in_group_reg <= bin_in_group_next;
            bars_done_reg    <= bars_done_next;
            frame_pos_reg    <= frame_pos_next;
            m_valid_reg      <= m_valid_next;
        end
        prod_reg      <= prod_next;
        mcand_reg     <= mcand_next;
        hmul_reg      <= hmul_next;
        step_reg      <= step_next;
        level_reg     <= level_next;
        m_payload_reg <= m_payload_next;
    end

    // Sequencer: magnitude, scaling, summing, averaging and output.
    always_comb begin
        state_next        = state_reg;
        group_sum_next    = group_sum_reg;
        bin_in_group_next = bin_in_group_reg;
        bars_done_next    = bars_done_reg;
        frame_pos_next    = frame_pos_reg;
        prod_next         = prod_reg;
        mcand_next        = mcand_reg;
        hmul_next         = hmul_reg;
        step_next         = step_reg;
        level_next        = level_reg;
        m_payload_next    = m_payload_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        mag_start         = 1'b0;
        div_start         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (bars_done_reg >= BARS_FULL) begin
                        // Trailing bin: only the frame position moves, unless the frame ends and all counters restart.
                        if (frame_end) begin
                            group_sum_next    = '0;
                            bin_in_group_next = '0;
                            bars_done_next    = '0;
                            frame_pos_next    = '0;
                        end else begin
                            frame_pos_next = FRAME_W'(frame_pos_inc);
                        end
                    end else begin
                        mag_start  = 1'b1;
                        state_next = ST_MAG;
                    end
                end
            end
            ST_MAG: begin
                if (mag_rsp.done) begin
                    prod_next  = '0;
                    mcand_next = PW'(mag_rsp.mag);
                    hmul_next  = bar_height_reg;
                    step_next  = '0;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                // One bar_height bit per cycle, least significant first.
                prod_next  = prod_reg + (hmul_reg[0] ? mcand_reg : '0);
                mcand_next = mcand_reg << 1;
                hmul_next  = hmul_reg >> 1;
                step_next  = step_reg + 1'b1;
                if (step_reg == SCALE_LAST) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                group_sum_next = sum_sat;
                if (group_close) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    bin_in_group_next = count;
                    frame_pos_next    = FRAME_W'(frame_pos_inc);
                    state_next        = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient > SUM_W'(bar_height_reg)) begin
                        level_next = bar_height_reg;
                    end else begin
                        level_next = div_rsp.quotient[BAR_HEIGHT_W-1:0];
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_payload_next.bar_index = INDEX_W'(bars_done_reg);
                    m_payload_next.bar_level = level_reg;
                    m_payload_next.last_bar  = (bars_done_reg == BARS_LAST);
                    group_sum_next           = '0;
                    bin_in_group_next        = '0;
                    if (bars_inc >= BARS_FULL && frame_end) begin
                        bars_done_next = '0;
                        frame_pos_next = '0;
                    end else begin
                        bars_done_next = bars_inc;
                        frame_pos_next = FRAME_W'(frame_pos_inc);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// File: rtl/sbm_magnitude.sv
// ============================================================================
// sbm_magnitude: bit-serial magnitude of a complex bin
// Forms re^2 + im^2 by shift and add, one multiplier bit per cycle, then takes
// the integer square root two radicand bits per cycle.
// ============================================================================
module sbm_magnitude
    import sbm_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [BIN_WIDTH-1:0] re,
    input  logic signed [BIN_WIDTH-1:0] im,
    output sbm_mag_rsp_t                rsp
);

    localparam int W  = BIN_WIDTH;
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

    sbm_mag_state_t state_reg, state_next;
    logic [W-1:0]   a_reg, a_next;
    logic [W-1:0]   b_reg, b_next;
    logic [2*W-1:0] ma_reg, ma_next;
    logic [2*W-1:0] mb_reg, mb_next;
    logic [2*W-1:0] n_reg, n_next;
    logic [W:0]     rem_reg, rem_next;
    logic [W-1:0]   root_reg, root_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           done_reg, done_next;

    logic [W-1:0]   re_u, im_u, re_abs, im_abs;
    logic [W+1:0]   rem_sh, trial;
    logic           ge;

    // Absolute values of the two's complement parts.
    assign re_u   = re;
    assign im_u   = im;
    assign re_abs = re_u[W-1] ? (~re_u + 1'b1) : re_u;
    assign im_abs = im_u[W-1] ? (~im_u + 1'b1) : im_u;

    // One root digit: bring down two radicand bits and try the next bit.
    assign rem_sh = {rem_reg[W-1:0], n_reg[2*W-1:2*W-2]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MAG_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    // Sequencer: square phase, then root phase.
    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        n_next     = n_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            MAG_IDLE: begin
                if (start) begin
                    a_next     = re_abs;
                    b_next     = im_abs;
                    ma_next    = (2*W)'(re_abs);
                    mb_next    = (2*W)'(im_abs);
                    n_next     = '0;
                    cnt_next   = '0;
                    state_next = MAG_SQUARE;
                end
            end
            MAG_SQUARE: begin
                n_next  = n_reg + (a_reg[0] ? ma_reg : '0) + (b_reg[0] ? mb_reg : '0);
                a_next  = a_reg >> 1;
                b_next  = b_reg >> 1;
                ma_next = ma_reg << 1;
                mb_next = mb_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = MAG_ROOT;
                end
            end
            MAG_ROOT: begin
                rem_next  = ge ? (W+1)'(rem_sh - trial) : (W+1)'(rem_sh);
                root_next = {root_reg[W-2:0], ge};
                n_next    = n_reg << 2;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    done_next  = 1'b1;
                    state_next = MAG_IDLE;
                end
            end
            default: begin
                state_next = MAG_IDLE;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.mag  = root_reg;

endmodule

// File: rtl/sbm_divider.sv
// ============================================================================
// sbm_divider: restoring serial divider for the bar average
// Divides the group sum by the bin count, one quotient bit per cycle.
// ============================================================================
module sbm_divider
    import sbm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [BPB_W-1:0] divisor,
    output sbm_div_rsp_t     rsp
);

    localparam int CW = $clog2(SUM_W);
    localparam logic [CW-1:0] LAST_STEP = CW'(SUM_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SUM_W-1:0] dq_reg, dq_next;
    logic [BPB_W-1:0] rem_reg, rem_next;
    logic [BPB_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    logic [BPB_W:0]   trial;
    logic             ge;

    // Partial remainder with the next dividend bit brought down.
    assign trial = {rem_reg, dq_reg[SUM_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    // The dividend register shifts out dividend bits and takes quotient bits.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        if (busy_reg) begin
            rem_next = ge ? BPB_W'(trial - {1'b0, dvs_reg}) : BPB_W'(trial);
            dq_next  = {dq_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

// File: rtl/sbm_checker.sv
// ============================================================================
// sbm_checker: port-level checks of the spectrum bar meter
// Watches the bar output over time and is bound to the top level.
// ============================================================================
module sbm_checker
    import sbm_pkg::*;
#(
    parameter int NUM_BARS = NUM_BARS_DEF
) (
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input sbm_out_t m_payload
);

    logic [INDEX_W-1:0] exp_index_reg, exp_index_next;

    // Bar index expected on the next delivered item.
    always_comb begin
        exp_index_next = exp_index_reg;
        if (m_valid && m_ready) begin
            exp_index_next = m_payload.last_bar ? '0 : m_payload.bar_index + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_index_reg <= '0;
        end else begin
            exp_index_reg <= exp_index_next;
        end
    end

    // A stalled item holds its bar.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("bar item changed while stalled");

    // Bars of a frame come out in order and the next frame starts at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.bar_index == exp_index_reg)
        else $error("bar index out of sequence");

    // The last bar of a frame carries the last index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.last_bar |-> m_payload.bar_index == INDEX_W'(NUM_BARS - 1))
        else $error("last bar flag on wrong index");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("bar item valid after reset");

endmodule

bind spectrum_bar_meter_core sbm_checker #(
    .NUM_BARS (NUM_BARS)
) u_sbm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

// File: bench/spectrum_bar_meter_core_tb.sv
// ============================================================================
// spectrum_bar_meter_core_tb: self-checking bench for the bar meter core
// Feeds complex FFT bins through the valid/ready input with random gaps,
// drains bar items with random stalls and compares every bar against a
// bit-exact prediction of magnitude, scaling, averaging, clamping and framing.
// Register settings are changed between phases over the APB port.
// ============================================================================
module spectrum_bar_meter_core_tb;
    import sbm_pkg::*;

    localparam int BAR_COUNT      = NUM_BARS_DEF;
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_CAP     = 30;

    localparam logic [BIN_WIDTH-1:0] PART_MAX = {1'b0, {(BIN_WIDTH-1){1'b1}}};
    localparam logic [BIN_WIDTH-1:0] PART_MIN = {1'b1, {(BIN_WIDTH-1){1'b0}}};
    localparam logic [BIN_WIDTH-1:0] PART_NEG1 = {BIN_WIDTH{1'b1}};

    // Predicts bar levels from accepted bins and holds them until they leave.
    class bar_level_board;
        logic [BAR_HEIGHT_W-1:0] bar_height;
        logic [BPB_W-1:0]        bins_per_bar;
        logic [FRAME_W-1:0]      frame_bins;
        logic [SUM_W-1:0]        group_sum;
        logic [BPB_W-1:0]        bin_in_group;
        int unsigned             bars_done;
        logic [FRAME_W-1:0]      frame_position;
        sbm_out_t                pending_bars[$];
        int unsigned             errors;
        int unsigned             bins_taken;
        int unsigned             bars_seen;

        function void clear();
            bar_height     = BAR_HEIGHT_RST;
            bins_per_bar   = BINS_PER_BAR_RST;
            frame_bins     = FRAME_BINS_RST;
            group_sum      = '0;
            bin_in_group   = '0;
            bars_done      = 0;
            frame_position = '0;
            errors         = 0;
            bins_taken     = 0;
            bars_seen      = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_BAR_HEIGHT:   bar_height   = value[BAR_HEIGHT_W-1:0];
                REG_BINS_PER_BAR: bins_per_bar = value[BPB_W-1:0];
                REG_FRAME_BINS:   frame_bins   = value[FRAME_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] register_value(logic [1:0] idx);
            case (idx)
                REG_BAR_HEIGHT:   return DATA_W'(bar_height);
                REG_BINS_PER_BAR: return DATA_W'(bins_per_bar);
                REG_FRAME_BINS:   return DATA_W'(frame_bins);
                default:          return '0;
            endcase
        endfunction

        function void report(string what, longint unsigned want, longint unsigned got);
            if (errors < REPORT_CAP) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            end
            errors++;
        endfunction

        // Exact floor of the square root of re^2 + im^2, one result bit at a time.
        function longint unsigned bin_magnitude(sbm_in_t b);
            longint          re;
            longint          im;
            longint unsigned power;
            longint unsigned root;
            longint unsigned trial;
            re    = longint'($signed(b.bin_real));
            im    = longint'($signed(b.bin_imag));
            power = re * re + im * im;
            root  = 0;
            for (int k = 28; k >= 0; k--) begin
                trial = root | (64'd1 << k);
                if (trial * trial <= power) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        // Advances the bar state by one accepted bin.
        function void take_bin(sbm_in_t b);
            longint unsigned contrib;
            longint unsigned total;
            longint unsigned level;
            longint unsigned count;
            longint unsigned per_bar;
            sbm_out_t        bar;
            bins_taken++;
            per_bar = (bins_per_bar == 0) ? 1 : bins_per_bar;
            if (bars_done < BAR_COUNT) begin
                contrib = (bin_magnitude(b) * bar_height) >> SCALE_SHIFT;
                total   = group_sum + contrib;
                if (total > SUM_MAX) begin
                    total = SUM_MAX;
                end
                count = bin_in_group + 1;
                if (count >= per_bar) begin
                    level = total / count;
                    if (level > bar_height) begin
                        level = bar_height;
                    end
                    bar.bar_index = INDEX_W'(bars_done);
                    bar.bar_level = BAR_HEIGHT_W'(level);
                    bar.last_bar  = (bars_done == BAR_COUNT - 1);
                    pending_bars.push_back(bar);
                    bars_done++;
                    group_sum    = '0;
                    bin_in_group = '0;
                end else begin
                    group_sum    = SUM_W'(total);
                    bin_in_group = BPB_W'(count);
                end
            end
            // The frame restarts once all bars are out and the frame length is reached.
            if (bars_done >= BAR_COUNT && frame_position + 32'd1 >= frame_bins) begin
                group_sum      = '0;
                bin_in_group   = '0;
                bars_done      = 0;
                frame_position = '0;
            end else begin
                frame_position = frame_position + 1'b1;
            end
        endfunction

        function void match_bar(sbm_out_t got);
            sbm_out_t want;
            bars_seen++;
            if (pending_bars.size() == 0) begin
                if (errors < REPORT_CAP) begin
                    $display("%0t: unexpected bar item, expected none, actual index %0d level %0d",
                             $time, got.bar_index, got.bar_level);
                end
                errors++;
                return;
            end
            want = pending_bars.pop_front();
            if (got.bar_index !== want.bar_index) begin
                report("bar_index", want.bar_index, got.bar_index);
            end
            if (got.bar_level !== want.bar_level) begin
                report("bar_level", want.bar_level, got.bar_level);
            end
            if (got.last_bar !== want.last_bar) begin
                report("last_bar", want.last_bar, got.last_bar);
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    sbm_in_t           s_payload;
    logic              m_valid;
    logic              m_ready;
    sbm_out_t          m_payload;

    bar_level_board sb;
    bit             calm;
    int             stall_left;
    int             quiet_cycles;
    int             settings_used;

    spectrum_bar_meter_core #(
        .NUM_BARS(BAR_COUNT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always #2 aclk = ~aclk;

    // Idle length: mostly none or short, now and then long; none at all in calm stretches.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // One bin component: mostly random with a random scale, sometimes an extreme.
    function automatic logic [BIN_WIDTH-1:0] pick_part(bit loud);
        logic [BIN_WIDTH-1:0] v;
        v = BIN_WIDTH'($urandom);
        if (loud) begin
            v = $urandom_range(0, 1) ? PART_MIN + BIN_WIDTH'($urandom_range(0, 15))
                                     : PART_MAX - BIN_WIDTH'($urandom_range(0, 15));
        end else if ($urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 4))
                0:       v = PART_MIN;
                1:       v = PART_MAX;
                2:       v = '0;
                3:       v = PART_NEG1;
                default: v = BIN_WIDTH'(1);
            endcase
        end else begin
            v = $signed(v) >>> $urandom_range(0, BIN_WIDTH - 1);
        end
        return v;
    endfunction

    function automatic sbm_in_t make_bin(bit loud);
        sbm_in_t b;
        b.bin_real = pick_part(loud);
        b.bin_imag = pick_part(loud);
        return b;
    endfunction

    // Presents one bin and holds it until the core takes it.
    task automatic send_bin(sbm_in_t b);
        int gap;
        if ($urandom_range(0, 99) == 0) begin
            calm = !calm;
        end
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_pair(logic [BIN_WIDTH-1:0] re, logic [BIN_WIDTH-1:0] im);
        sbm_in_t b;
        b.bin_real = re;
        b.bin_imag = im;
        send_bin(b);
    endtask

    task automatic run_bins(int n, bit loud);
        repeat (n) send_bin(make_bin(loud));
    endtask

    // Waits until every predicted bar has left and the core has finished any bin.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_bars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write followed by a read back of the same register.
    task automatic program_register(logic [1:0] idx, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_register(idx, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== sb.register_value(idx)) begin
            sb.report("register read back", sb.register_value(idx), readback);
        end
    endtask

    task automatic configure(int unsigned height, int unsigned per_bar, int unsigned frame);
        drain();
        program_register(REG_BAR_HEIGHT, height);
        program_register(REG_BINS_PER_BAR, per_bar);
        program_register(REG_FRAME_BINS, frame);
        settings_used++;
    endtask

    // Result side: random stalls on m_ready.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Handshake monitor and watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.match_bar(m_payload);
            end
            if (s_valid && s_ready) begin
                sb.take_bin(s_payload);
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("spectrum_bar_meter_core_tb failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        sb = new;
        sb.clear();
        aclk          = 1'b0;
        calm          = 1'b0;
        stall_left    = 0;
        quiet_cycles  = 0;
        settings_used = 0;
        aresetn   <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        m_ready   <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: one bin per bar so every extreme gives its own level.
        configure(4096, 1, 64);
        send_pair('0, '0);
        send_pair(PART_MAX, PART_MAX);
        send_pair(PART_MIN, PART_MIN);
        send_pair(PART_MIN, PART_MAX);
        send_pair(PART_MAX, PART_MIN);
        send_pair(PART_MIN, '0);
        send_pair('0, PART_MIN);
        send_pair(BIN_WIDTH'(1), PART_NEG1);
        send_pair(BIN_WIDTH'(1 << 20), '0);
        send_pair('0, -BIN_WIDTH'(1 << 20));
        send_pair(BIN_WIDTH'(3 << 18), BIN_WIDTH'(4 << 18));
        send_pair(-BIN_WIDTH'(3 << 16), BIN_WIDTH'(4 << 16));

        // Zero bar height, zero bins per bar and an empty frame length.
        configure(0, 0, 0);
        send_pair(PART_MAX, PART_MIN);
        send_pair(BIN_WIDTH'(12345), PART_NEG1);
        send_pair(PART_MIN, PART_MIN);

        // Largest bar height with full-scale bins: the clamp is hit.
        configure(8191, 2, 70);
        send_pair(PART_MAX, PART_MAX);
        send_pair(PART_MIN, PART_MAX);
        send_pair(PART_MIN, PART_MIN);
        send_pair(BIN_WIDTH'(1), '0);

        // Random phases over a range of frame shapes.
        configure($urandom_range(16, 4096), 1, 100);
        run_bins(100, 1'b0);
        configure($urandom_range(16, 4096), 3, 192);
        run_bins(150, 1'b0);
        configure($urandom_range(16, 4096), 5, 64);
        run_bins(150, 1'b0);
        configure($urandom_range(0, 8191), $urandom_range(1, 6), $urandom_range(64, 600));
        run_bins(80, 1'b0);

        // Widest groups of full-scale bins: the group sum saturates.
        configure(8191, 255, 65535);
        run_bins(260, 1'b1);

        // Fewer bins per bar while a group is part full: it closes on the next bin.
        configure($urandom_range(16, 4096), 2, 300);
        run_bins(40, 1'b0);

        // A longer frame: discarded bins run on until the counters restart.
        configure(16, 1, 400);
        run_bins(200, 1'b0);

        // Back to the reset values.
        configure(256, 8, 512);
        run_bins(60, 1'b0);

        drain();
        if (sb.pending_bars.size() != 0) begin
            $display("%0t: %0d expected bar items never arrived", $time,
                     sb.pending_bars.size());
            sb.errors++;
        end
        $display("Run covered %0d bins and %0d bar items over %0d register settings,",
                 sb.bins_taken, sb.bars_seen, settings_used);
        $display("with bar heights 0 to 8191, 0 to 255 bins per bar and frames of 0 to 65535.");
        if (sb.errors == 0) begin
            $display("spectrum_bar_meter_core_tb passed");
        end else begin
            $display("spectrum_bar_meter_core_tb failed");
        end
        $finish;
    end
endmodule
